>>> hdl/dnh_pkg.sv
// Shared constants, types and scale functions for the diatonic note harmonizer.
`default_nettype none

package dnh_pkg;

    localparam int TRACK_COUNT_DEF = 4;
    localparam int VOICE_COUNT_DEF = 4;

    localparam int TRACK_W     = 8;
    localparam int MIDI_W      = 7;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_TRACK_EN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VOICE_EN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVALS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_HIGH   = 3'd5;

    localparam logic [15:0] VOICE_EN_RESET   = 16'h1111;
    localparam logic [63:0] INTERVAL_RESET   = 64'h1110_1110_1110_1110;
    localparam logic [55:0] VEL_OFFSET_RESET = 56'd66951118690564864;

    localparam logic [3:0] CODE_LIMIT = 4'd11;
    localparam logic [7:0] STYPE_CHROMATIC = 8'd0;
    localparam logic [7:0] STYPE_MINOR_LO  = 8'd2;
    localparam logic [7:0] STYPE_MINOR_HI  = 8'd4;

    typedef logic [MIDI_W-1:0] midi_t;
    typedef logic signed [3:0] step_t;
    typedef logic signed [6:0] offset_t;

    function automatic logic [3:0] scale_tone(input logic minor, input logic [2:0] deg);
        logic [3:0] tone;
        case (deg)
            3'd0: tone = 4'd0;
            3'd1: tone = 4'd2;
            3'd2: tone = minor ? 4'd3 : 4'd4;
            3'd3: tone = 4'd5;
            3'd4: tone = 4'd7;
            3'd5: tone = minor ? 4'd8 : 4'd9;
            3'd6: tone = minor ? 4'd10 : 4'd11;
            default: tone = 4'd0;
        endcase
        return tone;
    endfunction

    function automatic step_t degree_step(input logic [3:0] code);
        step_t st;
        case (code)
            4'd0:  st = 4'sd0;
            4'd1:  st = 4'sd2;
            4'd2:  st = -4'sd2;
            4'd3:  st = 4'sd4;
            4'd4:  st = -4'sd4;
            4'd5:  st = 4'sd7;
            4'd6:  st = -4'sd7;
            4'd7:  st = 4'sd3;
            4'd8:  st = -4'sd3;
            4'd9:  st = 4'sd5;
            4'd10: st = -4'sd5;
            default: st = 4'sd0;
        endcase
        return st;
    endfunction

    // Snap to the nearer degree, the lower one on a tie; above the top degree wraps to 0.
    function automatic logic [2:0] snap_degree(input logic minor, input logic [3:0] rel);
        logic [2:0] deg;
        logic       done;
        logic [3:0] cur;
        logic [3:0] prev;
        deg  = 3'd0;
        done = 1'b0;
        prev = 4'd0;
        for (int i = 0; i < 7; i++) begin
            cur = scale_tone(minor, 3'(i));
            if (!done) begin
                if (cur == rel) begin
                    deg  = 3'(i);
                    done = 1'b1;
                end else if (i > 0 && cur > rel) begin
                    if ((rel - prev) <= (cur - rel)) begin
                        deg = 3'(i - 1);
                    end else begin
                        deg = 3'(i);
                    end
                    done = 1'b1;
                end
            end
            prev = cur;
        end
        return deg;
    endfunction

endpackage

`default_nettype wire

>>> hdl/diatonic_note_harmonizer.sv
// Diatonic note harmonizer: config registers, three-stage voice pipeline, result serializer.
//
// Usage: write settings on the cfg channel (index 0..5, data in the low bits) while idle;
// cfg_ready is always high. Each input transfer on s_ carries a track number in s_tuser and
// a note and velocity in s_tdata. For an enabled track the block returns one transfer on m_
// per enabled voice with an interval code below 11, in voice order, with m_tlast on the
// final one; otherwise it returns the input note and velocity once with m_tlast set.
// The first result of an item passes the stage 1, 2 and 3 registers and the serializer
// register before it is offered on m_.
// One result transfers per cycle while m_tready is high; an item yields 1 to VOICE_COUNT
// results. All voices of an item are computed side by side in three register stages and
// held in a serializer that drives the output port; the next item advances while it drains.
// Reset clears the pipeline and loads the register defaults: harmonizer off on all tracks,
// voice 0 of each track enabled at unison with offset 0, voices 1 to 3 a third up with offset -10.
// A stall on m_tready holds the current result and fills the stages behind it; s_tready
// falls once all stages and the serializer hold items. Nothing is dropped or repeated.
`default_nettype none

module diatonic_note_harmonizer #(
    parameter int TRACK_COUNT = dnh_pkg::TRACK_COUNT_DEF,
    parameter int VOICE_COUNT = dnh_pkg::VOICE_COUNT_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [dnh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [dnh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [dnh_pkg::S_DATA_W-1:0]       s_tdata,   // note_in, velocity_in, zero fill
    input  wire [dnh_pkg::TRACK_W-1:0]        s_tuser,   // track_number
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [dnh_pkg::M_DATA_W-1:0]      m_tdata,   // note_out, velocity_out, zero fill
    output logic                              m_tlast
);
    import dnh_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    // configuration registers
    logic [3:0]  track_en_reg;
    logic [47:0] scale_reg;
    logic [15:0] voice_en_reg;
    logic [63:0] interval_reg;
    logic [55:0] vel_lo_reg;
    logic [55:0] vel_hi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_en_reg <= '0;
            scale_reg    <= '0;
            voice_en_reg <= VOICE_EN_RESET;
            interval_reg <= INTERVAL_RESET;
            vel_lo_reg   <= VEL_OFFSET_RESET;
            vel_hi_reg   <= VEL_OFFSET_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TRACK_EN:  track_en_reg <= cfg_data[3:0];
                REG_SCALE:     scale_reg    <= cfg_data[47:0];
                REG_VOICE_EN:  voice_en_reg <= cfg_data[15:0];
                REG_INTERVALS: interval_reg <= cfg_data;
                REG_VEL_LOW:   vel_lo_reg   <= cfg_data[55:0];
                REG_VEL_HIGH:  vel_hi_reg   <= cfg_data[55:0];
                default: ;
            endcase
        end
    end

    // handshake chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, ser_valid_reg;
    logic s1_ready, s2_ready, s3_ready, ser_ready, ser_load, out_xfer;

    assign out_xfer  = m_tvalid && m_tready;
    assign ser_ready = !ser_valid_reg || (m_tready && m_tlast);
    assign ser_load  = s3_valid_reg && ser_ready;
    assign s3_ready  = !s3_valid_reg || ser_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: track lookup, voice decode, octave split
    logic [TRACK_W-1:0] in_track;
    midi_t              in_note, in_vel;
    logic [1:0]         in_trk;
    logic               in_on;
    logic [11:0]        trk_scale;
    logic [3:0]         root_raw, in_root;
    logic [12:0]        oct_prod;
    logic [3:0]         in_oct;
    logic [6:0]         oct12;
    logic [3:0]         in_rem;
    logic [55:0]        vel_sel;
    logic               in_chrom, in_minor;

    assign in_track  = s_tuser;
    assign in_note   = s_tdata[6:0];
    assign in_vel    = s_tdata[13:7];
    assign in_trk    = in_track[1:0];
    assign in_on     = (in_track < TRACK_W'(TRACK_COUNT)) && track_en_reg[in_trk];
    assign trk_scale = scale_reg[6'(in_trk) * 6'd12 +: 12];
    assign root_raw  = trk_scale[11:8];
    assign in_root   = (root_raw >= 4'd12) ? root_raw - 4'd12 : root_raw;
    assign in_chrom  = trk_scale[7:0] == STYPE_CHROMATIC;
    assign in_minor  = (trk_scale[7:0] >= STYPE_MINOR_LO) && (trk_scale[7:0] <= STYPE_MINOR_HI);
    assign oct_prod  = 13'(in_note) * 13'd43;
    assign in_oct    = oct_prod[12:9];
    assign oct12     = 7'(in_oct) * 7'd12;
    assign in_rem    = 4'(in_note - oct12);
    assign vel_sel   = in_trk[1] ? vel_hi_reg : vel_lo_reg;

    logic [VOICE_COUNT-1:0] in_active;
    step_t                  in_step [VOICE_COUNT];
    offset_t                in_off  [VOICE_COUNT];

    for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_decode
        logic [3:0] slot;
        logic [3:0] code;
        assign slot         = {in_trk, 2'(v)};
        assign code         = interval_reg[{slot, 2'b00} +: 4];
        assign in_active[v] = in_on && voice_en_reg[slot] && (code < CODE_LIMIT);
        assign in_step[v]   = degree_step(code);
        assign in_off[v]    = vel_sel[6'({in_trk[0], 2'(v)}) * 6'd7 +: 7];
    end

    midi_t                  s1_note_reg, s1_vel_reg;
    logic [3:0]             s1_oct_reg, s1_rem_reg, s1_root_reg;
    logic                   s1_chrom_reg, s1_minor_reg;
    logic [VOICE_COUNT-1:0] s1_active_reg;
    step_t                  s1_step_reg [VOICE_COUNT];
    offset_t                s1_off_reg  [VOICE_COUNT];

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_note_reg   <= in_note;
            s1_vel_reg    <= in_vel;
            s1_oct_reg    <= in_oct;
            s1_rem_reg    <= in_rem;
            s1_root_reg   <= in_root;
            s1_chrom_reg  <= in_chrom;
            s1_minor_reg  <= in_minor;
            s1_active_reg <= in_active;
            s1_step_reg   <= in_step;
            s1_off_reg    <= in_off;
        end
    end

    // stage 2: degree snap, target degree, velocity clamp
    logic [4:0] rel_sum;
    logic [3:0] rel;
    logic [2:0] deg;

    assign rel_sum = 5'(s1_rem_reg) + 5'd12 - 5'(s1_root_reg);
    assign rel     = (rel_sum >= 5'd12) ? 4'(rel_sum - 5'd12) : 4'(rel_sum);
    assign deg     = snap_degree(s1_minor_reg, rel);

    logic [2:0]        t_idx  [VOICE_COUNT];
    logic signed [1:0] t_oo   [VOICE_COUNT];
    midi_t             t_vel  [VOICE_COUNT];

    for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_degree
        logic signed [4:0] tgt;
        logic signed [8:0] vsum;
        assign tgt  = $signed({2'b00, deg}) + 5'(s1_step_reg[v]);
        assign vsum = $signed({2'b00, s1_vel_reg}) + 9'(s1_off_reg[v]);
        always_comb begin
            if (tgt < 5'sd0) begin
                t_idx[v] = 3'(tgt + 5'sd7);
                t_oo[v]  = -2'sd1;
            end else if (tgt >= 5'sd7) begin
                t_idx[v] = 3'(tgt - 5'sd7);
                t_oo[v]  = 2'sd1;
            end else begin
                t_idx[v] = 3'(tgt);
                t_oo[v]  = 2'sd0;
            end
            if (vsum < 9'sd1) begin
                t_vel[v] = 7'd1;
            end else if (vsum > 9'sd127) begin
                t_vel[v] = 7'd127;
            end else begin
                t_vel[v] = 7'(vsum);
            end
        end
    end

    midi_t                  s2_note_reg, s2_vel_reg;
    logic [3:0]             s2_oct_reg, s2_root_reg;
    logic                   s2_chrom_reg, s2_minor_reg;
    logic [VOICE_COUNT-1:0] s2_active_reg;
    step_t                  s2_step_reg [VOICE_COUNT];
    logic [2:0]             s2_idx_reg  [VOICE_COUNT];
    logic signed [1:0]      s2_oo_reg   [VOICE_COUNT];
    midi_t                  s2_velc_reg [VOICE_COUNT];

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_note_reg   <= s1_note_reg;
            s2_vel_reg    <= s1_vel_reg;
            s2_oct_reg    <= s1_oct_reg;
            s2_root_reg   <= s1_root_reg;
            s2_chrom_reg  <= s1_chrom_reg;
            s2_minor_reg  <= s1_minor_reg;
            s2_active_reg <= s1_active_reg;
            s2_step_reg   <= s1_step_reg;
            s2_idx_reg    <= t_idx;
            s2_oo_reg     <= t_oo;
            s2_velc_reg   <= t_vel;
        end
    end

    // stage 3: harmony note, clamp, pass-through selection
    midi_t                  h_note [VOICE_COUNT];
    midi_t                  g_note [VOICE_COUNT];
    midi_t                  g_vel  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] g_mask;
    logic                   any_voice;

    assign any_voice = |s2_active_reg;
    assign g_mask    = any_voice ? s2_active_reg : VOICE_COUNT'(1);

    for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_note_calc
        logic signed [5:0] oct_adj;
        logic signed [8:0] base;
        logic signed [8:0] res;
        logic [7:0]        up12;
        midi_t             semi;
        midi_t             diat;
        assign oct_adj = $signed({2'b00, s2_oct_reg}) + 6'(s2_oo_reg[v]);
        assign base    = 9'(oct_adj) * 9'sd12;
        assign res     = base + $signed({5'b0, s2_root_reg})
                         + $signed({5'b0, scale_tone(s2_minor_reg, s2_idx_reg[v])});
        assign up12    = 8'(s2_note_reg) + 8'd12;
        always_comb begin
            if (s2_step_reg[v] == 4'sd7) begin
                semi = (up12 > 8'd127) ? 7'd127 : 7'(up12);
            end else if (s2_step_reg[v] == -4'sd7) begin
                semi = (s2_note_reg < 7'd12) ? 7'd0 : s2_note_reg - 7'd12;
            end else begin
                semi = s2_note_reg;
            end
            if (res < 9'sd0) begin
                diat = 7'd0;
            end else if (res > 9'sd127) begin
                diat = 7'd127;
            end else begin
                diat = 7'(res);
            end
            if (s2_step_reg[v] == 4'sd0) begin
                h_note[v] = s2_note_reg;
            end else if (s2_chrom_reg || s2_step_reg[v] == 4'sd7
                         || s2_step_reg[v] == -4'sd7) begin
                h_note[v] = semi;
            end else begin
                h_note[v] = diat;
            end
        end
        if (v == 0) begin : g_first
            assign g_note[v] = any_voice ? h_note[v] : s2_note_reg;
            assign g_vel[v]  = any_voice ? s2_velc_reg[v] : s2_vel_reg;
        end else begin : g_rest
            assign g_note[v] = h_note[v];
            assign g_vel[v]  = s2_velc_reg[v];
        end
    end

    logic [VOICE_COUNT-1:0] s3_mask_reg;
    midi_t                  s3_note_reg [VOICE_COUNT];
    midi_t                  s3_vel_reg  [VOICE_COUNT];

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_mask_reg <= g_mask;
            s3_note_reg <= g_note;
            s3_vel_reg  <= g_vel;
        end
    end

    // serializer: one result per transfer, lowest pending voice first
    logic [VOICE_COUNT-1:0] ser_pend_reg;
    logic [VOICE_COUNT-1:0] ser_pend_next;
    midi_t                  ser_note_reg [VOICE_COUNT];
    midi_t                  ser_vel_reg  [VOICE_COUNT];
    logic [VW-1:0]          ser_sel;

    assign ser_pend_next = ser_pend_reg & (ser_pend_reg - VOICE_COUNT'(1));

    always_comb begin
        ser_sel = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (ser_pend_reg[i]) begin
                ser_sel = VW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_pend_reg  <= '0;
        end else if (ser_load) begin
            ser_valid_reg <= 1'b1;
            ser_pend_reg  <= s3_mask_reg;
        end else if (out_xfer) begin
            ser_valid_reg <= !m_tlast;
            ser_pend_reg  <= ser_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            ser_note_reg <= s3_note_reg;
            ser_vel_reg  <= s3_vel_reg;
        end
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tlast  = ser_pend_next == '0;
    assign m_tdata  = {2'b00, ser_vel_reg[ser_sel], ser_note_reg[ser_sel]};

    a_pending_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> ser_pend_reg != '0)
        else $error("serializer valid with no pending voice");

    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && m_tlast && !ser_load) |=> !m_tvalid)
        else $error("output valid after final result drained");

    a_backpressure_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && ser_valid_reg))
        else $error("input stalled while a stage is empty");

endmodule

`default_nettype wire
